@@ rtl/core/dtq_pkg.sv @@
// ----------------------------------------------------------------------------
// dtq_pkg
// Types and constants shared by the deadline timer queue files.
// ----------------------------------------------------------------------------
`default_nettype none

package dtq_pkg;

    // Field widths fixed by the stream format.
    localparam int TIME_W     = 63;
    localparam int ID_W       = 16;
    localparam int CMD_W      = 2;
    localparam int KIND_W     = 2;
    localparam int STAT_W     = 2;
    localparam int S_TDATA_W  = 144;
    localparam int M_TDATA_W  = 152;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_SCHED  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_SCHED   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CANCEL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_IDLE    = 2'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_PAST      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_CAN_RD,
        ST_CAN_CMP,
        ST_SH_RD,
        ST_SH_WR,
        ST_POP,
        ST_HEAD_RD,
        ST_HEAD_LAT,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

@@ rtl/core/dtq_ram.sv @@
// ----------------------------------------------------------------------------
// dtq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/deadline_timer_queue_top.sv @@
// ----------------------------------------------------------------------------
// deadline_timer_queue_top
// Sorted timer queue of (deadline, entry id) pairs held in one RAM.
// ----------------------------------------------------------------------------
// The entries live in a circular buffer in one RAM, in ascending deadline
// order with equal deadlines in arrival order; a base pointer marks the
// earliest entry, and a copy of that entry is kept in registers. Every RAM
// access is a registered read followed by a compare or write, so cost grows
// with queue occupancy n. A rejected schedule or an idle tick goes straight
// to the output register; an accepted schedule moves later entries up from
// the tail and then reloads the head; a cancel searches from the head, then
// closes the gap and reloads the head; and a tick pops each expired entry,
// which only advances the base pointer and reloads the head. The single RAM
// port pair sets this cost. Output results wait in a register; the
// sequencer stalls there while the downstream side is not ready. No
// clearing pass is needed after reset.
`default_nettype none

module deadline_timer_queue_top #(
    parameter int QUEUE_DEPTH = 32,
    parameter int ID_BITS     = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // tdata: deadline[62:0], entry_id[78:63], now_time[141:79], zero pad.
    input  wire logic [dtq_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: command[1:0].
    input  wire logic [dtq_pkg::CMD_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // tdata: status[1:0], expired_id[17:2], expired_deadline[80:18],
    // rearm[81], next_deadline[144:82], queue_empty[145], zero pad.
    output logic [dtq_pkg::M_TDATA_W-1:0]      m_tdata,
    // tuser: event_kind[1:0].
    output logic [dtq_pkg::KIND_W-1:0]         m_tuser,
    output logic                               m_tlast
);

    import dtq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam int DW = TIME_W + SW;
    localparam logic [CW:0]   DEPTH_X = (CW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] FULL_C  = CW'(QUEUE_DEPTH);

    // Logical slot to physical RAM address, wrapping once.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] b,
                                           input logic [CW-1:0] i);
        logic [CW:0] sum;
        sum = (CW + 1)'(b) + (CW + 1)'(i);
        if (sum >= DEPTH_X)
        begin
            sum = sum - DEPTH_X;
        end
        return sum[AW-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     base_reg, base_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              m_tvalid_next;

    logic [TIME_W-1:0] dl_reg, dl_next;
    logic [SW-1:0]     id_reg, id_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] head_dl_reg, head_dl_next;
    logic [SW-1:0]     head_id_reg, head_id_next;
    logic [KIND_W-1:0] res_kind_reg, res_kind_next;
    logic [STAT_W-1:0] res_stat_reg, res_stat_next;
    logic [SW-1:0]     res_id_reg, res_id_next;
    logic [TIME_W-1:0] res_dl_reg, res_dl_next;
    logic              res_rearm_reg, res_rearm_next;

    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [KIND_W-1:0]    m_tuser_reg, m_tuser_next;
    logic                 m_tlast_reg, m_tlast_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DW-1:0]     mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DW-1:0]     mem_rdata;
    logic [TIME_W-1:0] rd_dl;
    logic [SW-1:0]     rd_id;

    logic [TIME_W-1:0] in_dl;
    logic [SW-1:0]     in_id;
    logic [TIME_W-1:0] in_now;
    logic              s_fire;
    logic              out_free;
    logic              more_due;

    assign in_dl    = s_tdata[TIME_W-1:0];
    assign in_id    = s_tdata[TIME_W +: SW];
    assign in_now   = s_tdata[TIME_W+ID_W +: TIME_W];
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;
    assign rd_dl    = mem_rdata[TIME_W-1:0];
    assign rd_id    = mem_rdata[TIME_W +: SW];
    assign more_due = (count_reg != '0) && (head_dl_reg <= now_reg);

    // Entry storage.
    dtq_ram #(
        .WIDTH (DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Next state and register updates.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        base_next      = base_reg;
        idx_next       = idx_reg;
        dl_next        = dl_reg;
        id_next        = id_reg;
        now_next       = now_reg;
        head_dl_next   = head_dl_reg;
        head_id_next   = head_id_reg;
        res_kind_next  = res_kind_reg;
        res_stat_next  = res_stat_reg;
        res_id_next    = res_id_reg;
        res_dl_next    = res_dl_reg;
        res_rearm_next = res_rearm_reg;
        m_tvalid_next  = m_tvalid && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        m_tlast_next   = m_tlast_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    dl_next        = in_dl;
                    id_next        = in_id;
                    now_next       = in_now;
                    res_id_next    = in_id;
                    res_dl_next    = in_dl;
                    res_rearm_next = 1'b0;
                    res_stat_next  = STAT_OK;
                    idx_next       = '0;
                    case (s_tuser)
                        CMD_SCHED:
                        begin
                            res_kind_next = KIND_SCHED;
                            if (in_dl <= in_now)
                            begin
                                res_stat_next = STAT_PAST;
                                state_next    = ST_EMIT;
                            end
                            else if (count_reg == FULL_C)
                            begin
                                res_stat_next = STAT_FULL;
                                state_next    = ST_EMIT;
                            end
                            else
                            begin
                                res_rearm_next = (count_reg == '0) ||
                                                 (in_dl < head_dl_reg);
                                idx_next       = count_reg;
                                state_next     = ST_INS_RD;
                            end
                        end
                        CMD_CANCEL:
                        begin
                            res_kind_next = KIND_CANCEL;
                            state_next    = ST_CAN_RD;
                        end
                        CMD_TICK:
                        begin
                            if (count_reg == '0 || head_dl_reg > in_now)
                            begin
                                res_kind_next = KIND_IDLE;
                                res_id_next   = '0;
                                res_dl_next   = '0;
                                state_next    = ST_EMIT;
                            end
                            else
                            begin
                                state_next = ST_POP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Insertion from the tail: move later entries up by one slot.
            ST_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    count_next = count_reg + 1'b1;
                    state_next = ST_HEAD_RD;
                end
                else
                begin
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                if (rd_dl > dl_reg)
                begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = ST_INS_RD;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    state_next = ST_HEAD_RD;
                end
            end

            // Cancel search from the head.
            ST_CAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    res_stat_next = STAT_NOT_FOUND;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    state_next = ST_CAN_CMP;
                end
            end
            ST_CAN_CMP:
            begin
                if (rd_dl == dl_reg && rd_id == id_reg)
                begin
                    state_next = ST_SH_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_CAN_RD;
                end
            end

            // Close the gap left by a cancelled entry.
            ST_SH_RD:
            begin
                if ((CW + 1)'(idx_reg) + 1'b1 >= (CW + 1)'(count_reg))
                begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_HEAD_RD;
                end
                else
                begin
                    state_next = ST_SH_WR;
                end
            end
            ST_SH_WR:
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = ST_SH_RD;
            end

            // Pop the earliest entry by advancing the base.
            ST_POP:
            begin
                res_kind_next = KIND_EXPIRED;
                res_stat_next = STAT_OK;
                res_id_next   = head_id_reg;
                res_dl_next   = head_dl_reg;
                base_next     = phys(base_reg, CW'(1));
                count_next    = count_reg - 1'b1;
                state_next    = ST_HEAD_RD;
            end

            // Reload the head copy.
            ST_HEAD_RD:
            begin
                state_next = ST_HEAD_LAT;
            end
            ST_HEAD_LAT:
            begin
                head_dl_next = rd_dl;
                head_id_next = rd_id;
                state_next   = ST_EMIT;
            end

            // Hand the result to the output register.
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_kind_reg;
                    m_tdata_next  = '0;
                    m_tdata_next[1:0]     = res_stat_reg;
                    m_tdata_next[17:2]    = ID_W'(res_id_reg);
                    m_tdata_next[80:18]   = res_dl_reg;
                    m_tdata_next[81]      = res_rearm_reg;
                    m_tdata_next[144:82]  = (count_reg != '0) ? head_dl_reg : '0;
                    m_tdata_next[145]     = (count_reg == '0);
                    if (res_kind_reg == KIND_EXPIRED && more_due)
                    begin
                        m_tlast_next = 1'b0;
                        state_next   = ST_POP;
                    end
                    else
                    begin
                        m_tlast_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // RAM control and input handshake.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = phys(base_reg, idx_reg);
        mem_wdata = {id_reg, dl_reg};
        mem_raddr = phys(base_reg, '0);
        s_tready  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_INS_RD:
            begin
                mem_raddr = phys(base_reg, idx_reg - 1'b1);
                mem_we    = (idx_reg == '0);
            end
            ST_INS_CMP:
            begin
                mem_we = 1'b1;
                if (rd_dl > dl_reg)
                begin
                    mem_wdata = mem_rdata;
                end
            end
            ST_CAN_RD:
            begin
                mem_raddr = phys(base_reg, idx_reg);
            end
            ST_SH_RD:
            begin
                mem_raddr = phys(base_reg, idx_reg + 1'b1);
            end
            ST_SH_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
            end
            ST_HEAD_RD:
            begin
                mem_raddr = phys(base_reg, '0);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            base_reg  <= '0;
            idx_reg   <= '0;
            m_tvalid  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            base_reg  <= base_next;
            idx_reg   <= idx_next;
            m_tvalid  <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        dl_reg        <= dl_next;
        id_reg        <= id_next;
        now_reg       <= now_next;
        head_dl_reg   <= head_dl_next;
        head_id_reg   <= head_id_next;
        res_kind_reg  <= res_kind_next;
        res_stat_reg  <= res_stat_next;
        res_id_reg    <= res_id_next;
        res_dl_reg    <= res_dl_next;
        res_rearm_reg <= res_rearm_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
        m_tlast_reg   <= m_tlast_next;
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;
    assign m_tlast = m_tlast_reg;

endmodule

`default_nettype wire

@@ rtl/core/dtq_checker.sv @@
// ----------------------------------------------------------------------------
// dtq_checker
// Port-level checks on the result stream of the deadline timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [dtq_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [dtq_pkg::KIND_W-1:0]    m_tuser,
    input wire logic                          m_tlast
);

    import dtq_pkg::*;

    // A stalled item stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    // Only an expired entry can be followed by more items of the same tick.
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_EXPIRED |-> m_tlast)
        else $error("single-item reply without last");

    // An empty queue reports no next deadline.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[145] |-> m_tdata[144:82] == '0)
        else $error("empty queue with a next deadline");

    // Re-arm only on a successful schedule that leaves the queue non-empty.
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[81] |-> m_tuser == KIND_SCHED &&
            m_tdata[1:0] == STAT_OK && !m_tdata[145] &&
            m_tdata[144:82] == m_tdata[80:18])
        else $error("re-arm on a wrong result");

endmodule

bind deadline_timer_queue_top dtq_checker u_dtq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
